/* rtl/core/mdio_pkg.sv */
// Shared types and constants for the MDIO management master.
// Used by the interfaces' users, the frame engine and the top level.
package mdio_pkg;

   localparam int unsigned DEFAULT_PREAMBLE_BITS = 32;
   localparam int unsigned FRAME_BITS            = 32;
   localparam int unsigned HDR_BITS              = 14;
   localparam int unsigned TA_END                = 16;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_TICK  = 2'd2
   } mdio_req_code_type;

   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] ST_BITS  = 2'b01;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        wr_start;
      logic [1:0]  wr_opcode;
      logic [4:0]  wr_phy;
      logic [4:0]  wr_regaddr;
      logic [15:0] wr_data;
      logic        mdio_in;
   } mdio_req_type;

   typedef struct packed {
      logic        rd_busy;
      logic        rd_fail;
      logic [1:0]  rd_opcode;
      logic [4:0]  rd_phy;
      logic [4:0]  rd_regaddr;
      logic [15:0] rd_data;
      logic        mdio_out;
      logic        mdio_drive;
      logic        done_pulse;
      logic        error_pulse;
   } mdio_rsp_type;

endpackage

/* rtl/core/mdio_if.sv */
// Valid/ready channel interfaces for MDIO master requests and responses.
// No dependencies.
interface mdio_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic        wr_start;
   logic [1:0]  wr_opcode;
   logic [4:0]  wr_phy;
   logic [4:0]  wr_regaddr;
   logic [15:0] wr_data;
   logic        mdio_in;

   modport source (
      output valid, req_type, wr_start, wr_opcode, wr_phy, wr_regaddr, wr_data, mdio_in,
      input  ready
   );
   modport sink (
      input  valid, req_type, wr_start, wr_opcode, wr_phy, wr_regaddr, wr_data, mdio_in,
      output ready
   );
endinterface

interface mdio_rsp_if;
   logic        valid;
   logic        ready;
   logic        rd_busy;
   logic        rd_fail;
   logic [1:0]  rd_opcode;
   logic [4:0]  rd_phy;
   logic [4:0]  rd_regaddr;
   logic [15:0] rd_data;
   logic        mdio_out;
   logic        mdio_drive;
   logic        done_pulse;
   logic        error_pulse;

   modport source (
      output valid, rd_busy, rd_fail, rd_opcode, rd_phy, rd_regaddr, rd_data,
             mdio_out, mdio_drive, done_pulse, error_pulse,
      input  ready
   );
   modport sink (
      input  valid, rd_busy, rd_fail, rd_opcode, rd_phy, rd_regaddr, rd_data,
             mdio_out, mdio_drive, done_pulse, error_pulse,
      output ready
   );
endinterface

/* rtl/core/mdio_management_master.sv */
// MDIO clause 22 management master: one command register driven by register and MDC tick
// transactions, every request producing one response. Depends on mdio_pkg, mdio_if, mdio_engine.
// A request transaction is taken every clock cycle: the command register and frame position
// update at the accepting edge, and the response lands in a two-entry output buffer (output
// register plus skid register), so req_chan.ready drops only when both entries hold responses
// the sink has not taken. A frame spans PREAMBLE_BITS + 32 tick transactions.
module mdio_management_master #(
   parameter int unsigned PREAMBLE_BITS = mdio_pkg::DEFAULT_PREAMBLE_BITS
) (
   input logic        clock,
   input logic        reset,
   mdio_req_if.sink   req_chan,
   mdio_rsp_if.source rsp_chan
);
   import mdio_pkg::*;

   mdio_req_type req;
   mdio_rsp_type rsp;
   logic         accept;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   mdio_rsp_type out_ff, out_in;
   mdio_rsp_type skid_ff, skid_in;

   assign req.req_type   = req_chan.req_type;
   assign req.wr_start   = req_chan.wr_start;
   assign req.wr_opcode  = req_chan.wr_opcode;
   assign req.wr_phy     = req_chan.wr_phy;
   assign req.wr_regaddr = req_chan.wr_regaddr;
   assign req.wr_data    = req_chan.wr_data;
   assign req.mdio_in    = req_chan.mdio_in;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && !skid_valid_ff;

   mdio_engine #(
      .PREAMBLE_BITS(PREAMBLE_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req),
      .rsp   (rsp)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_in       = rsp;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.rd_busy     = out_ff.rd_busy;
   assign rsp_chan.rd_fail     = out_ff.rd_fail;
   assign rsp_chan.rd_opcode   = out_ff.rd_opcode;
   assign rsp_chan.rd_phy      = out_ff.rd_phy;
   assign rsp_chan.rd_regaddr  = out_ff.rd_regaddr;
   assign rsp_chan.rd_data     = out_ff.rd_data;
   assign rsp_chan.mdio_out    = out_ff.mdio_out;
   assign rsp_chan.mdio_drive  = out_ff.mdio_drive;
   assign rsp_chan.done_pulse  = out_ff.done_pulse;
   assign rsp_chan.error_pulse = out_ff.error_pulse;

endmodule

/* rtl/core/mdio_engine.sv */
// Command register and clause 22 frame sequencer: one state update per accepted transaction.
// Depends on mdio_pkg.
module mdio_engine #(
   parameter int unsigned PREAMBLE_BITS = mdio_pkg::DEFAULT_PREAMBLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  mdio_pkg::mdio_req_type req,
   output mdio_pkg::mdio_rsp_type rsp
);
   import mdio_pkg::*;

   localparam int unsigned TotalBits = PREAMBLE_BITS + FRAME_BITS;
   localparam int unsigned PosW      = $clog2(TotalBits);
   localparam logic [PosW-1:0] LastPos     = PosW'(TotalBits - 1);
   localparam logic [PosW-1:0] PreamblePos = PosW'(PREAMBLE_BITS);

   logic            busy_ff, busy_in;
   logic            fail_ff, fail_in;
   logic [1:0]      opcode_ff, opcode_in;
   logic [4:0]      phy_ff, phy_in;
   logic [4:0]      regaddr_ff, regaddr_in;
   logic [15:0]     data_ff, data_in;
   logic [PosW-1:0] pos_ff, pos_in;

   logic [PosW-1:0] q_wide;
   logic [4:0]      q;
   logic [13:0]     hdr;
   logic            is_read;
   logic            lvl, drv, done, err;

   always_comb begin
      busy_in    = busy_ff;
      fail_in    = fail_ff;
      opcode_in  = opcode_ff;
      phy_in     = phy_ff;
      regaddr_in = regaddr_ff;
      data_in    = data_ff;
      pos_in     = pos_ff;
      lvl        = 1'b1;
      drv        = 1'b0;
      done       = 1'b0;
      err        = 1'b0;
      q_wide     = pos_ff - PreamblePos;
      q          = q_wide[4:0];
      hdr        = {ST_BITS, opcode_ff, phy_ff, regaddr_ff};
      is_read    = opcode_ff == OP_READ;
      case (req.req_type)
         REQ_WRITE: begin
            if (!busy_ff) begin
               opcode_in  = req.wr_opcode;
               phy_in     = req.wr_phy;
               regaddr_in = req.wr_regaddr;
               data_in    = req.wr_data;
               fail_in    = 1'b0;
               if (req.wr_start) begin
                  busy_in = 1'b1;
                  pos_in  = '0;
               end
            end
         end
         REQ_TICK: begin
            if (busy_ff) begin
               if (pos_ff < PreamblePos) begin
                  lvl = 1'b1;
                  drv = 1'b1;
               end else if (q < 5'(HDR_BITS)) begin
                  lvl = hdr[4'(HDR_BITS - 1) - q[3:0]];
                  drv = 1'b1;
               end else if (q < 5'(TA_END)) begin
                  if (is_read) begin
                     if (q[0] && req.mdio_in) begin
                        fail_in = 1'b1;
                     end
                  end else begin
                     lvl = ~q[0];
                     drv = 1'b1;
                  end
               end else begin
                  if (is_read) begin
                     data_in = {data_ff[14:0], req.mdio_in};
                  end else begin
                     lvl = data_ff[~q[3:0]];
                     drv = 1'b1;
                  end
               end
               if (pos_ff == LastPos) begin
                  busy_in = 1'b0;
                  pos_in  = '0;
                  done    = 1'b1;
                  err     = is_read && fail_in;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      rsp.rd_busy     = busy_in;
      rsp.rd_fail     = fail_in;
      rsp.rd_opcode   = opcode_in;
      rsp.rd_phy      = phy_in;
      rsp.rd_regaddr  = regaddr_in;
      rsp.rd_data     = data_in;
      rsp.mdio_out    = lvl;
      rsp.mdio_drive  = drv;
      rsp.done_pulse  = done;
      rsp.error_pulse = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         fail_ff    <= 1'b0;
         opcode_ff  <= '0;
         phy_ff     <= '0;
         regaddr_ff <= '0;
         data_ff    <= '0;
         pos_ff     <= '0;
      end else if (accept) begin
         busy_ff    <= busy_in;
         fail_ff    <= fail_in;
         opcode_ff  <= opcode_in;
         phy_ff     <= phy_in;
         regaddr_ff <= regaddr_in;
         data_ff    <= data_in;
         pos_ff     <= pos_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> pos_ff == '0)
      else $error("bit position not parked while idle");

   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp.error_pulse |-> rsp.done_pulse)
      else $error("error without frame completion");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept && rsp.done_pulse |=> !busy_ff)
      else $error("busy still set after frame completion");

   a_release_read: assert property (@(posedge clock) disable iff (reset)
      accept && req.req_type == REQ_TICK && busy_ff && !rsp.mdio_drive
      |-> opcode_ff == OP_READ)
      else $error("line released during a write frame");

   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      accept && busy_ff && req.req_type == REQ_WRITE
      |=> $stable(opcode_ff) && $stable(phy_ff) && $stable(regaddr_ff))
      else $error("command fields changed by a write while busy");
`endif

endmodule

/* tb/sv/mdio_master_checker.sv */
// Scoreboard for the MDIO management master: predicts the register view for every
// accepted request transaction and compares it with each accepted response transaction.
// Depends on mdio_pkg and the mdio_req_if / mdio_rsp_if interfaces.
module mdio_master_checker (
   input  logic        clock,
   input  logic        reset,
   mdio_req_if         req_mon,
   mdio_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned outstanding
);
   import mdio_pkg::*;

   localparam int unsigned FRAME_TICKS = DEFAULT_PREAMBLE_BITS + FRAME_BITS;

   logic         busy_q;
   logic         fail_q;
   logic [1:0]   opcode_q;
   logic [4:0]   phy_q;
   logic [4:0]   regaddr_q;
   logic [15:0]  data_q;
   logic [6:0]   bit_pos_q;
   mdio_rsp_type expected_views[$];
   mdio_req_type req_seen;
   mdio_rsp_type rsp_seen;
   mdio_rsp_type want;

   function automatic mdio_rsp_type advance_command_register(input mdio_req_type r);
      mdio_rsp_type v;
      logic [13:0]  header;
      int unsigned  q;
      logic         is_read;
      v = '0;
      v.mdio_out = 1'b1;
      if (r.req_type == REQ_WRITE) begin
         if (!busy_q) begin
            opcode_q  = r.wr_opcode;
            phy_q     = r.wr_phy;
            regaddr_q = r.wr_regaddr;
            data_q    = r.wr_data;
            fail_q    = 1'b0;
            if (r.wr_start) begin
               busy_q    = 1'b1;
               bit_pos_q = '0;
            end
         end
      end else if (r.req_type == REQ_TICK && busy_q) begin
         is_read = (opcode_q == OP_READ);
         header  = {ST_BITS, opcode_q, phy_q, regaddr_q};
         if (bit_pos_q < DEFAULT_PREAMBLE_BITS) begin
            v.mdio_drive = 1'b1;
         end else begin
            q = bit_pos_q - DEFAULT_PREAMBLE_BITS;
            if (q < HDR_BITS) begin
               v.mdio_out   = header[HDR_BITS - 1 - q];
               v.mdio_drive = 1'b1;
            end else if (q < TA_END) begin
               if (is_read) begin
                  if (q == TA_END - 1 && r.mdio_in) fail_q = 1'b1;
               end else begin
                  v.mdio_out   = (q == HDR_BITS);
                  v.mdio_drive = 1'b1;
               end
            end else if (is_read) begin
               data_q = {data_q[14:0], r.mdio_in};
            end else begin
               v.mdio_out   = data_q[FRAME_BITS - 1 - q];
               v.mdio_drive = 1'b1;
            end
         end
         if (bit_pos_q + 1 >= FRAME_TICKS) begin
            busy_q        = 1'b0;
            bit_pos_q     = '0;
            v.done_pulse  = 1'b1;
            v.error_pulse = is_read && fail_q;
         end else begin
            bit_pos_q = bit_pos_q + 1'b1;
         end
      end
      v.rd_busy    = busy_q;
      v.rd_fail    = fail_q;
      v.rd_opcode  = opcode_q;
      v.rd_phy     = phy_q;
      v.rd_regaddr = regaddr_q;
      v.rd_data    = data_q;
      return v;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         busy_q    = 1'b0;
         fail_q    = 1'b0;
         opcode_q  = '0;
         phy_q     = '0;
         regaddr_q = '0;
         data_q    = '0;
         bit_pos_q = '0;
         expected_views.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_seen = {rsp_mon.rd_busy, rsp_mon.rd_fail, rsp_mon.rd_opcode, rsp_mon.rd_phy,
                        rsp_mon.rd_regaddr, rsp_mon.rd_data, rsp_mon.mdio_out,
                        rsp_mon.mdio_drive, rsp_mon.done_pulse, rsp_mon.error_pulse};
            if (expected_views.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual %0h", $time,
                        rsp_seen);
               mismatch_count++;
            end else begin
               want = expected_views.pop_front();
               check_field("rd_busy", want.rd_busy, rsp_seen.rd_busy);
               check_field("rd_fail", want.rd_fail, rsp_seen.rd_fail);
               check_field("rd_opcode", want.rd_opcode, rsp_seen.rd_opcode);
               check_field("rd_phy", want.rd_phy, rsp_seen.rd_phy);
               check_field("rd_regaddr", want.rd_regaddr, rsp_seen.rd_regaddr);
               check_field("rd_data", want.rd_data, rsp_seen.rd_data);
               check_field("mdio_out", want.mdio_out, rsp_seen.mdio_out);
               check_field("mdio_drive", want.mdio_drive, rsp_seen.mdio_drive);
               check_field("done_pulse", want.done_pulse, rsp_seen.done_pulse);
               check_field("error_pulse", want.error_pulse, rsp_seen.error_pulse);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req_seen = {req_mon.req_type, req_mon.wr_start, req_mon.wr_opcode, req_mon.wr_phy,
                        req_mon.wr_regaddr, req_mon.wr_data, req_mon.mdio_in};
            expected_views.push_back(advance_command_register(req_seen));
         end
      end
      outstanding = expected_views.size();
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the MDIO management master testbench: clock, reset, request stimulus,
// response back-pressure and the final verdict. Depends on mdio_pkg, the channel
// interfaces, mdio_management_master and mdio_master_checker.
module testbench;
   import mdio_pkg::*;

   localparam logic [1:0]  REQ_UNUSED       = 2'd3;
   localparam logic [1:0]  OP_UNDEF_LO      = 2'd0;
   localparam logic [1:0]  OP_UNDEF_HI      = 2'd3;
   localparam int unsigned FRAME_TICKS      = DEFAULT_PREAMBLE_BITS + FRAME_BITS;
   localparam int unsigned FAIL_SAMPLE_TICK = DEFAULT_PREAMBLE_BITS + TA_END - 1;
   localparam int unsigned ITEM_TARGET      = 1900;
   localparam int unsigned RSP_HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES     = 10;
   localparam int unsigned CYCLE_LIMIT      = 400000;

   logic        clock;
   logic        reset;
   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned issued_count;
   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned outstanding;
   bit          hold_rsp;

   mdio_req_if req_chan();
   mdio_rsp_if rsp_chan();

   mdio_management_master u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mdio_master_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("mdio_management_master verification failed");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_chan.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic mdio_req_type compose(input logic [1:0] kind, input logic start,
                                            input logic [1:0] opcode, input logic [4:0] phy,
                                            input logic [4:0] regaddr, input logic [15:0] data,
                                            input logic level);
      mdio_req_type r;
      r.req_type   = kind;
      r.wr_start   = start;
      r.wr_opcode  = opcode;
      r.wr_phy     = phy;
      r.wr_regaddr = regaddr;
      r.wr_data    = data;
      r.mdio_in    = level;
      return r;
   endfunction

   function automatic mdio_req_type random_item(input logic [1:0] kind);
      return compose(kind, 1'($urandom_range(1)), 2'($urandom_range(3)),
                     5'($urandom_range(31)), 5'($urandom_range(31)),
                     16'($urandom_range(65535)), 1'($urandom_range(1)));
   endfunction

   function automatic logic [1:0] noise_kind(input bit with_tick);
      case ($urandom_range(with_tick ? 3 : 2))
         0: return REQ_WRITE;
         1: return REQ_READ;
         2: return REQ_UNUSED;
         default: return REQ_TICK;
      endcase
   endfunction

   function automatic logic [1:0] random_opcode();
      int unsigned pick;
      pick = $urandom_range(19);
      if (pick < 9) return OP_WRITE;
      if (pick < 18) return OP_READ;
      if (pick == 18) return OP_UNDEF_LO;
      return OP_UNDEF_HI;
   endfunction

   task automatic issue(input mdio_req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.req_type   = item.req_type;
      req_chan.wr_start   = item.wr_start;
      req_chan.wr_opcode  = item.wr_opcode;
      req_chan.wr_phy     = item.wr_phy;
      req_chan.wr_regaddr = item.wr_regaddr;
      req_chan.wr_data    = item.wr_data;
      req_chan.mdio_in    = item.mdio_in;
      do @(posedge clock); while (!req_chan.ready);
      issued_count++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      wait (outstanding == 0);
   endtask

   task automatic run_frame(input logic [1:0] opcode, input bit fail_answer,
                            input int unsigned ticks);
      mdio_req_type r;
      int unsigned  t;
      r = random_item(REQ_WRITE);
      r.wr_start  = 1'b1;
      r.wr_opcode = opcode;
      issue(r);
      for (t = 0; t < ticks; t++) begin
         if ($urandom_range(99) < 6) issue(random_item(noise_kind(1'b0)));
         r = random_item(REQ_TICK);
         if (t == FAIL_SAMPLE_TICK) r.mdio_in = fail_answer;
         issue(r);
      end
   endtask

   initial begin
      int unsigned frame_index;
      int unsigned phase;
      int unsigned ticks;
      logic [1:0]  opcode;
      bit          fail_answer;
      reset               = 1'b1;
      hold_rsp            = 1'b0;
      issued_count        = 0;
      send_idle_pct       = 9;
      rsp_idle_pct        = 66;
      req_chan.valid      = 1'b0;
      req_chan.req_type   = REQ_READ;
      req_chan.wr_start   = 1'b0;
      req_chan.wr_opcode  = '0;
      req_chan.wr_phy     = '0;
      req_chan.wr_regaddr = '0;
      req_chan.wr_data    = '0;
      req_chan.mdio_in    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      issue(compose(REQ_READ, 1'b0, OP_UNDEF_LO, 5'd0, 5'd0, 16'h0000, 1'b0));
      issue(compose(REQ_TICK, 1'b0, OP_UNDEF_LO, 5'd0, 5'd0, 16'h0000, 1'b0));
      issue(compose(REQ_TICK, 1'b1, OP_UNDEF_HI, 5'd31, 5'd31, 16'hFFFF, 1'b1));
      issue(compose(REQ_WRITE, 1'b0, OP_UNDEF_HI, 5'd31, 5'd31, 16'hFFFF, 1'b1));
      issue(compose(REQ_READ, 1'b1, OP_UNDEF_HI, 5'd31, 5'd31, 16'hFFFF, 1'b1));
      issue(compose(REQ_UNUSED, 1'b1, OP_UNDEF_HI, 5'd31, 5'd31, 16'hFFFF, 1'b1));
      issue(compose(REQ_TICK, 1'b0, OP_WRITE, 5'd0, 5'd0, 16'h0000, 1'b1));
      issue(compose(REQ_WRITE, 1'b0, OP_WRITE, 5'd0, 5'd31, 16'h0000, 1'b0));
      issue(compose(REQ_READ, 1'b0, OP_UNDEF_LO, 5'd0, 5'd0, 16'h0000, 1'b0));
      issue(compose(REQ_WRITE, 1'b0, OP_READ, 5'd31, 5'd0, 16'hAAAA, 1'b1));
      issue(compose(REQ_READ, 1'b0, OP_UNDEF_LO, 5'd0, 5'd0, 16'h0000, 1'b0));
      issue(compose(REQ_WRITE, 1'b0, OP_UNDEF_LO, 5'd10, 5'd21, 16'h5555, 1'b0));
      issue(compose(REQ_UNUSED, 1'b0, OP_UNDEF_LO, 5'd0, 5'd0, 16'h0000, 1'b0));
      issue(compose(REQ_READ, 1'b0, OP_UNDEF_LO, 5'd0, 5'd0, 16'h0000, 1'b0));

      frame_index = 0;
      phase       = 0;
      while (issued_count < ITEM_TARGET) begin
         if (phase == 0 && issued_count >= ITEM_TARGET / 3) begin
            settle();
            send_idle_pct = 66;
            rsp_idle_pct  = 9;
            phase         = 1;
         end else if (phase == 1 && issued_count >= 2 * ITEM_TARGET / 3) begin
            settle();
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
            hold_rsp      = 1'b1;
            phase         = 2;
         end
         if (frame_index < 5) begin
            case (frame_index)
               0: opcode = OP_WRITE;
               1: opcode = OP_READ;
               2: opcode = OP_READ;
               3: opcode = OP_UNDEF_LO;
               default: opcode = OP_UNDEF_HI;
            endcase
            run_frame(opcode, frame_index == 1, FRAME_TICKS);
            frame_index++;
         end else if ($urandom_range(99) < 85) begin
            opcode      = random_opcode();
            fail_answer = 1'($urandom_range(1));
            ticks = ($urandom_range(9) == 0) ? $urandom_range(FRAME_TICKS - 1, 1) : FRAME_TICKS;
            run_frame(opcode, fail_answer, ticks);
            frame_index++;
         end else begin
            repeat ($urandom_range(8, 1)) issue(random_item(noise_kind(1'b1)));
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("mdio_management_master verification clean");
      else
         $display("mdio_management_master verification failed");
      $finish;
   end

endmodule
